### rtl/lpc_pkg.sv
package lpc_pkg;

    // Fixed field widths of the point and result transfers.
    localparam int PX_W  = 11;
    localparam int PY_W  = 10;
    localparam int POS_W = 2;

    // Widest vertex coordinate the block is built for, and the product width.
    localparam int COORD_MAX = 10;
    localparam int K_W       = PX_W + 2;
    localparam int PROD_W    = 24;

    // Register port geometry: four registers at 8-byte strides.
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // Register values after reset.
    localparam logic [DATA_W-1:0] LEFT_XS_RST  = 64'd492521222838627475;
    localparam logic [DATA_W-1:0] LEFT_YS_RST  = 64'd811277401418960896;
    localparam logic [DATA_W-1:0] RIGHT_XS_RST = 64'd1022178374538737064;
    localparam logic [DATA_W-1:0] RIGHT_YS_RST = 64'd811245423090010112;

    // Defaults for the top-level parameters.
    localparam int VERTEX_COUNT_DEF = 6;
    localparam int COORD_BITS_DEF   = 10;

    typedef enum logic [1:0] {
        REG_LEFT_XS  = 2'd0,
        REG_LEFT_YS  = 2'd1,
        REG_RIGHT_XS = 2'd2,
        REG_RIGHT_YS = 2'd3
    } t_reg_idx;

    typedef enum logic [POS_W-1:0] {
        POS_LEFT    = 2'd0,
        POS_BETWEEN = 2'd1,
        POS_RIGHT   = 2'd2
    } t_pos;

    // Segment chosen for one boundary, after the first stage.
    typedef struct packed {
        logic                        found;
        logic                        flat;
        logic [PY_W-1:0]             dyy;
        logic signed [COORD_MAX:0]   dx;
        logic [COORD_MAX-1:0]        dy;
        logic signed [K_W-1:0]       k;
    } t_seg;

    // Products for one boundary, after the second stage.
    typedef struct packed {
        logic                     found;
        logic                     flat;
        logic                     k_pos;
        logic signed [PROD_W-1:0] n;
        logic signed [PROD_W-1:0] m;
    } t_prod;

endpackage

### rtl/lane_position_classify_unit.sv
// Channel     Direction  Handshake                    Payload
// point       in         i_in_valid / o_in_ready      i_point_x, i_point_y
// result      out        o_out_valid / i_out_ready    o_lane_position
// register    in/out     psel, penable, pwrite        paddr, pwdata, prdata
//
// Each point transfer yields one result through three register stages (segment
// choice, products, compare), and one point may enter on every cycle unless a
// stalled result holds it back. Reset is synchronous and active low; it restores
// the boundary registers and empties the pipeline. A stalled result holds only
// the stages behind it that are full, so bubbles are squeezed out and nothing
// is lost or repeated.
module lane_position_classify_unit
    import lpc_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [PX_W-1:0]   i_point_x,
    input  logic [PY_W-1:0]   i_point_y,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [POS_W-1:0]  o_lane_position,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int REG_BITS = VERTEX_COUNT * COORD_BITS;

    logic [REG_BITS-1:0] left_xs, left_ys, right_xs, right_ys;

    // Valid bits travel alongside the payload of each stage.
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    t_seg       seg_l, seg_r;
    t_prod      prod_l, prod_r;
    t_pos       r_pos, n_pos;
    logic       left_hit, right_hit;

    lpc_cfg_regs #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_BITS   (COORD_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_left_xs  (left_xs),
        .o_left_ys  (left_ys),
        .o_right_xs (right_xs),
        .o_right_ys (right_ys)
    );

    // A stage loads when it is empty or when the stage after it loads too.
    assign en3        = !r_v3 || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage one: pick the segment that holds the point's y on each boundary.
    // The left side biases its offset by one, so that a strict "left of" test
    // becomes a compare against the floored boundary x.
    lpc_seg_select #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_BITS   (COORD_BITS)
    ) u_sel_left (
        .i_clk  (i_clk),
        .i_en   (en1),
        .i_xs   (left_xs),
        .i_ys   (left_ys),
        .i_px   (i_point_x),
        .i_py   (i_point_y),
        .i_bias (1'b1),
        .o_seg  (seg_l)
    );

    lpc_seg_select #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_BITS   (COORD_BITS)
    ) u_sel_right (
        .i_clk  (i_clk),
        .i_en   (en1),
        .i_xs   (right_xs),
        .i_ys   (right_ys),
        .i_px   (i_point_x),
        .i_py   (i_point_y),
        .i_bias (1'b0),
        .o_seg  (seg_r)
    );

    // Stage two: form the cross products. With a rising span dy, the floored
    // quotient of n by dy is at least k exactly when n is at least k * dy, so
    // no division is needed.
    lpc_side_mult u_mul_left (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_seg  (seg_l),
        .o_prod (prod_l)
    );

    lpc_side_mult u_mul_right (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_seg  (seg_r),
        .o_prod (prod_r)
    );

    // Stage three: compare and classify. On a flat segment the boundary x is
    // simply the start vertex, so the sign of the offset decides. The left
    // test takes precedence when the boundaries cross.
    always_comb begin
        left_hit  = prod_l.found &&
                    !(prod_l.flat ? prod_l.k_pos : (prod_l.n < prod_l.m));
        right_hit = prod_r.found &&
                    (prod_r.flat ? prod_r.k_pos : (prod_r.n < prod_r.m));
        if (left_hit) begin
            n_pos = POS_LEFT;
        end else if (right_hit) begin
            n_pos = POS_RIGHT;
        end else begin
            n_pos = POS_BETWEEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_pos <= n_pos;
        end
    end

    assign o_out_valid     = r_v3;
    assign o_lane_position = r_pos;

endmodule

### rtl/lpc_cfg_regs.sv
module lpc_cfg_regs
    import lpc_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    localparam int REG_BITS    = VERTEX_COUNT * COORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [REG_BITS-1:0] o_left_xs,
    output logic [REG_BITS-1:0] o_left_ys,
    output logic [REG_BITS-1:0] o_right_xs,
    output logic [REG_BITS-1:0] o_right_ys
);

    logic [REG_BITS-1:0] r_left_xs, r_left_ys, r_right_xs, r_right_ys;
    logic                wr_en;
    t_reg_idx            idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_xs  <= LEFT_XS_RST[REG_BITS-1:0];
            r_left_ys  <= LEFT_YS_RST[REG_BITS-1:0];
            r_right_xs <= RIGHT_XS_RST[REG_BITS-1:0];
            r_right_ys <= RIGHT_YS_RST[REG_BITS-1:0];
        end else if (wr_en) begin
            case (idx)
                REG_LEFT_XS:  r_left_xs  <= pwdata[REG_BITS-1:0];
                REG_LEFT_YS:  r_left_ys  <= pwdata[REG_BITS-1:0];
                REG_RIGHT_XS: r_right_xs <= pwdata[REG_BITS-1:0];
                REG_RIGHT_YS: r_right_ys <= pwdata[REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LEFT_XS:  prdata = DATA_W'(r_left_xs);
            REG_LEFT_YS:  prdata = DATA_W'(r_left_ys);
            REG_RIGHT_XS: prdata = DATA_W'(r_right_xs);
            REG_RIGHT_YS: prdata = DATA_W'(r_right_ys);
            default:      prdata = '0;
        endcase
    end

    assign o_left_xs  = r_left_xs;
    assign o_left_ys  = r_left_ys;
    assign o_right_xs = r_right_xs;
    assign o_right_ys = r_right_ys;

endmodule

### rtl/lpc_seg_select.sv
module lpc_seg_select
    import lpc_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    localparam int REG_BITS    = VERTEX_COUNT * COORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [REG_BITS-1:0] i_xs,
    input  logic [REG_BITS-1:0] i_ys,
    input  logic [PX_W-1:0]     i_px,
    input  logic [PY_W-1:0]     i_py,
    input  logic                i_bias,
    output t_seg                o_seg
);

    t_seg r_seg, n_seg;

    // Scan the segments from the top down so that the lowest match wins.
    always_comb begin
        logic [COORD_BITS-1:0]       x0, x1, y0, y1, sx0, sx1, sy0, sy1;
        logic signed [COORD_BITS:0]  dxl;
        logic                        hit;
        sx0 = '0;
        sx1 = '0;
        sy0 = '0;
        sy1 = '0;
        hit = 1'b0;
        for (int i = VERTEX_COUNT - 1; i >= 1; i--) begin
            x0 = i_xs[(i-1)*COORD_BITS +: COORD_BITS];
            x1 = i_xs[i*COORD_BITS +: COORD_BITS];
            y0 = i_ys[(i-1)*COORD_BITS +: COORD_BITS];
            y1 = i_ys[i*COORD_BITS +: COORD_BITS];
            if (i_py >= PY_W'(y0) && i_py <= PY_W'(y1)) begin
                hit = 1'b1;
                sx0 = x0;
                sx1 = x1;
                sy0 = y0;
                sy1 = y1;
            end
        end
        dxl         = $signed({1'b0, sx1}) - $signed({1'b0, sx0});
        n_seg.found = hit;
        n_seg.flat  = (sy1 == sy0);
        n_seg.dyy   = i_py - PY_W'(sy0);
        n_seg.dx    = (COORD_MAX+1)'(dxl);
        n_seg.dy    = COORD_MAX'(sy1 - sy0);
        // The bias turns a strict compare into one against the floor.
        n_seg.k     = $signed({2'b00, i_px}) - $signed(K_W'(sx0))
                      + $signed(K_W'(i_bias));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

### rtl/lpc_side_mult.sv
module lpc_side_mult
    import lpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_seg  i_seg,
    output t_prod o_prod
);

    t_prod r_prod, n_prod;

    always_comb begin
        logic signed [PROD_W-1:0] a_dyy, a_dx, a_k, a_dy;
        a_dyy        = PROD_W'($signed({1'b0, i_seg.dyy}));
        a_dx         = PROD_W'(i_seg.dx);
        a_k          = PROD_W'(i_seg.k);
        a_dy         = PROD_W'($signed({1'b0, i_seg.dy}));
        n_prod.found = i_seg.found;
        n_prod.flat  = i_seg.flat;
        n_prod.k_pos = (i_seg.k > 0);
        n_prod.n     = a_dyy * a_dx;
        n_prod.m     = a_k * a_dy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule
